FILE: hdl/grbf_pkg.sv
package grbf_pkg;

   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int QDEPTH        = 2;
   localparam int EXP_LIMIT_INT = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_MU_MIN       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MU_STEP      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAUSS_COEFF  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_COEFF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTERS_USED = 3'd4;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_EVAL  = 1'b1;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_EVAL  = 2'd1;
   localparam logic [1:0] KIND_ZERO  = 2'd2;

   typedef struct packed {
      logic               func;
      logic [5:0]         channel;
      logic [4:0]         center_index;
      logic signed [31:0] weight_value;
      logic signed [31:0] sample_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] phi_value;
      logic signed [31:0] slope_value;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [5:0]         channel;
      logic [4:0]         center;
      logic signed [31:0] data;
   } cmd_type;

   typedef struct packed {
      logic signed [31:0] mu_min;
      logic [30:0]        mu_step;
      logic [30:0]        gauss_coeff;
      logic [30:0]        deriv_coeff;
      logic [5:0]         centers_used;
   } cfg_type;

   // exp(-k), Q.24
   function automatic logic [24:0] exp_int_tab(input logic [3:0] k);
      logic [24:0] v;
      unique case (k)
         4'd0:    v = 25'd16777216;
         4'd1:    v = 25'd6171993;
         4'd2:    v = 25'd2270549;
         4'd3:    v = 25'd835288;
         4'd4:    v = 25'd307285;
         4'd5:    v = 25'd113044;
         4'd6:    v = 25'd41587;
         4'd7:    v = 25'd15299;
         4'd8:    v = 25'd5628;
         4'd9:    v = 25'd2070;
         4'd10:   v = 25'd762;
         4'd11:   v = 25'd280;
         default: v = 25'd0;
      endcase
      return v;
   endfunction

   // exp(-i/16), Q.24
   function automatic logic [24:0] exp_frac_tab(input logic [4:0] i);
      logic [24:0] v;
      unique case (i)
         5'd0:    v = 25'd16777216;
         5'd1:    v = 25'd15760736;
         5'd2:    v = 25'd14805841;
         5'd3:    v = 25'd13908801;
         5'd4:    v = 25'd13066109;
         5'd5:    v = 25'd12274474;
         5'd6:    v = 25'd11530801;
         5'd7:    v = 25'd10832185;
         5'd8:    v = 25'd10175896;
         5'd9:    v = 25'd9559369;
         5'd10:   v = 25'd8980197;
         5'd11:   v = 25'd8436118;
         5'd12:   v = 25'd7924996;
         5'd13:   v = 25'd7444845;
         5'd14:   v = 25'd6993784;
         5'd15:   v = 25'd6570052;
         5'd16:   v = 25'd6171993;
         default: v = 25'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: hdl/grbf_front.sv
module grbf_front import grbf_pkg::*; #(
   parameter int CHANNELS    = 64,
   parameter int NUM_CENTERS = 32
) (
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd
);

   logic ch_ok;
   logic ci_ok;
   logic keep;

   assign ch_ok = int'(req_data.channel) < CHANNELS;
   assign ci_ok = int'(req_data.center_index) < NUM_CENTERS;

   // drop weight writes that fall outside the table
   assign keep = (req_data.func == FUNC_EVAL) || (ch_ok && ci_ok);

   assign req_full = q_full;
   assign q_push   = req_push && !q_full && keep;

   always_comb begin
      q_cmd.channel = req_data.channel;
      q_cmd.center  = req_data.center_index;
      if (req_data.func == FUNC_EVAL) begin
         q_cmd.kind = ch_ok ? KIND_EVAL : KIND_ZERO;
         q_cmd.data = req_data.sample_value;
      end else begin
         q_cmd.kind = KIND_WRITE;
         q_cmd.data = req_data.weight_value;
      end
   end

endmodule

FILE: hdl/grbf_queue.sv
module grbf_queue import grbf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type pop_data
);

   localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCW = $clog2(QDEPTH + 1);

   cmd_type          slot_ff [QDEPTH];
   logic [QAW-1:0]   wptr_ff, wptr_in;
   logic [QAW-1:0]   rptr_ff, rptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == QCW'(QDEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = slot_ff[rptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == QAW'(QDEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == QAW'(QDEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/grbf_back.sv
module grbf_back import grbf_pkg::*; #(
   parameter int CHANNELS    = 64,
   parameter int NUM_CENTERS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    q_empty,
   input  cmd_type q_cmd,
   output logic    q_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int DEPTH = CHANNELS * NUM_CENTERS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(NUM_CENTERS + 1);
   localparam int DW    = CW + 34;
   localparam int ACCW  = CW + 49;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_D    = 4'd1;
   localparam logic [3:0] ST_SQ   = 4'd2;
   localparam logic [3:0] ST_XH   = 4'd3;
   localparam logic [3:0] ST_XL   = 4'd4;
   localparam logic [3:0] ST_X    = 4'd5;
   localparam logic [3:0] ST_FR   = 4'd6;
   localparam logic [3:0] ST_E    = 4'd7;
   localparam logic [3:0] ST_WE   = 4'd8;
   localparam logic [3:0] ST_PH   = 4'd9;
   localparam logic [3:0] ST_PL   = 4'd10;
   localparam logic [3:0] ST_M    = 4'd11;
   localparam logic [3:0] ST_ML   = 4'd12;
   localparam logic [3:0] ST_OUT  = 4'd13;

   logic signed [31:0] mem [DEPTH];

   logic [3:0]            state_ff, state_in;
   logic signed [31:0]    z_ff, z_in;
   logic signed [DW-1:0]  mu_ff, mu_in;
   logic signed [DW-1:0]  d_ff, d_in;
   logic [AW-1:0]         raddr_ff, raddr_in;
   logic signed [31:0]    w_ff;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         last_ff, last_in;
   logic                  far_ff, far_in;
   logic [15:0]           ql_ff, ql_in;
   logic [62:0]           xa_ff, xa_in;
   logic [3:0]            k_ff, k_in;
   logic [24:0]           bi_ff, bi_in;
   logic                  ezero_ff, ezero_in;
   logic signed [32:0]    p_ff, p_in;
   logic signed [65:0]    t_ff, t_in;
   logic signed [ACCW-1:0] acc_ff, acc_in;
   logic signed [63:0]    s_ff, s_in;
   logic [15:0]           sl_ff, sl_in;
   logic                  bpos_ff, bpos_in;
   logic                  bneg_ff, bneg_in;
   logic signed [65:0]    mh_ff, mh_in;
   logic signed [65:0]    mul_ff;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;

   logic signed [32:0]    op_a, op_b;
   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_waddr;
   logic                  out_free;

   logic [DW-1:0]         ad;
   logic [63:0]           xsum, xeff;
   logic                  x_ge;
   logic [24:0]           fr_diff;
   logic [24:0]           fr_now;
   logic [49:0]           e_sum;
   logic [16:0]           e_now;
   logic signed [63:0]    s_sum;
   logic [47:0]           sh;
   logic signed [67:0]    m_fine, m_sel, neg_m;
   logic signed [ACCW-1:0] acc_sh;
   logic                  phi_ovf, slope_ovf;
   int                    kc;

   assign ad        = d_ff[DW-1] ? DW'(-d_ff) : DW'(d_ff);
   assign xsum      = {1'b0, xa_ff} + 64'(mul_ff[46:16]);
   assign x_ge      = xsum >= 64'(EXP_LIMIT_INT * 65536);
   assign xeff      = (cfg.gauss_coeff == '0) ? 64'd0 : xsum;
   assign fr_diff   = exp_frac_tab({1'b0, xeff[15:12]})
                    - exp_frac_tab({1'b0, xeff[15:12]} + 5'd1);
   assign fr_now    = bi_ff - 25'(mul_ff[32:12]);
   assign e_sum     = 50'(mul_ff[48:0]) + 50'h0_8000_0000;
   assign e_now     = ezero_ff ? 17'd0 : e_sum[48:32];
   assign s_sum     = s_ff + 64'(t_ff) + 64'(mul_ff >>> 16);
   assign sh        = s_ff[63:16];
   assign m_fine    = 68'(mh_ff) + 68'(mul_ff >>> 16);
   assign neg_m     = -m_sel;
   assign acc_sh    = acc_ff >>> 16;
   assign phi_ovf   = !((&acc_sh[ACCW-1:31]) || !(|acc_sh[ACCW-1:31]));
   assign slope_ovf = !((&neg_m[67:31]) || !(|neg_m[67:31]));
   assign out_free  = !out_valid_ff || rsp_pop;
   assign mem_waddr = AW'(int'(q_cmd.channel) * NUM_CENTERS + int'(q_cmd.center));

   assign kc = (q_cmd.kind == KIND_EVAL && cfg.centers_used < 6'd2) ? 2 :
               (int'(cfg.centers_used) > NUM_CENTERS) ? NUM_CENTERS :
               (cfg.centers_used < 6'd2) ? 2 : int'(cfg.centers_used);

   always_comb begin
      if (cfg.deriv_coeff == '0) begin
         m_sel = '0;
      end else if (bpos_ff) begin
         m_sel = 68'sd1 <<< 40;
      end else if (bneg_ff) begin
         m_sel = -(68'sd1 <<< 40);
      end else begin
         m_sel = m_fine;
      end
   end

   always_comb begin
      state_in     = state_ff;
      z_in         = z_ff;
      mu_in        = mu_ff;
      d_in         = d_ff;
      raddr_in     = raddr_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      far_in       = far_ff;
      ql_in        = ql_ff;
      xa_in        = xa_ff;
      k_in         = k_ff;
      bi_in        = bi_ff;
      ezero_in     = ezero_ff;
      p_in         = p_ff;
      t_in         = t_ff;
      acc_in       = acc_ff;
      s_in         = s_ff;
      sl_in        = sl_ff;
      bpos_in      = bpos_ff;
      bneg_in      = bneg_ff;
      mh_in        = mh_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      // hold the last product stable while a result waits
      op_a         = $signed(33'(sl_ff));
      op_b         = $signed(33'(cfg.deriv_coeff));

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               unique case (q_cmd.kind)
                  KIND_WRITE: begin
                     mem_we = 1'b1;
                     q_pop  = 1'b1;
                  end
                  KIND_ZERO: begin
                     if (out_free) begin
                        q_pop        = 1'b1;
                        out_valid_in = 1'b1;
                        out_in       = '0;
                     end
                  end
                  KIND_EVAL: begin
                     q_pop    = 1'b1;
                     z_in     = q_cmd.data;
                     mu_in    = DW'(cfg.mu_min);
                     raddr_in = AW'(int'(q_cmd.channel) * NUM_CENTERS);
                     cnt_in   = '0;
                     last_in  = CW'(kc - 1);
                     acc_in   = '0;
                     s_in     = '0;
                     state_in = ST_D;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_D: begin
            mem_re   = 1'b1;
            d_in     = DW'(z_ff) - mu_ff;
            mu_in    = mu_ff + DW'(cfg.mu_step);
            raddr_in = raddr_ff + 1'b1;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            far_in   = |ad[DW-1:32];
            op_a     = $signed(33'(ad[31:0]));
            op_b     = $signed(33'(ad[31:0]));
            state_in = ST_XH;
         end
         ST_XH: begin
            ql_in    = mul_ff[31:16];
            op_a     = $signed(33'(mul_ff[63:32]));
            op_b     = $signed(33'(cfg.gauss_coeff));
            state_in = ST_XL;
         end
         ST_XL: begin
            xa_in    = mul_ff[62:0];
            op_a     = $signed(33'(ql_ff));
            op_b     = $signed(33'(cfg.gauss_coeff));
            state_in = ST_X;
         end
         ST_X: begin
            ezero_in = (cfg.gauss_coeff != '0) && (far_ff || x_ge);
            k_in     = xeff[19:16];
            bi_in    = exp_frac_tab({1'b0, xeff[15:12]});
            op_a     = $signed(33'(fr_diff));
            op_b     = $signed(33'(xeff[11:0]));
            state_in = ST_FR;
         end
         ST_FR: begin
            op_a     = $signed(33'(exp_int_tab(k_ff)));
            op_b     = $signed(33'(fr_now));
            state_in = ST_E;
         end
         ST_E: begin
            op_a     = 33'(w_ff);
            op_b     = $signed(33'(e_now));
            state_in = ST_WE;
         end
         ST_WE: begin
            acc_in   = acc_ff + ACCW'(mul_ff);
            p_in     = mul_ff[48:16];
            op_a     = mul_ff[48:16];
            op_b     = 33'(d_ff >>> 16);
            state_in = ST_PH;
         end
         ST_PH: begin
            t_in     = mul_ff;
            op_a     = p_ff;
            op_b     = $signed(33'(d_ff[15:0]));
            state_in = ST_PL;
         end
         ST_PL: begin
            s_in = s_sum;
            if (cnt_ff == last_ff) begin
               state_in = ST_M;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_D;
            end
         end
         ST_M: begin
            sl_in    = s_ff[15:0];
            bpos_in  = !sh[47] && (|sh[46:32]);
            bneg_in  = sh[47] && !((&sh[47:32]) && (|sh[31:0]));
            op_a     = $signed(sh[32:0]);
            op_b     = $signed(33'(cfg.deriv_coeff));
            state_in = ST_ML;
         end
         ST_ML: begin
            mh_in    = mul_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               out_valid_in        = 1'b1;
               out_in.phi_value    = phi_ovf ? (acc_sh[ACCW-1] ? 32'sh80000000 : 32'sh7fffffff)
                                             : acc_sh[31:0];
               out_in.slope_value  = slope_ovf ? (neg_m[67] ? 32'sh80000000 : 32'sh7fffffff)
                                               : neg_m[31:0];
               out_in.saturated    = phi_ovf || slope_ovf;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff     <= z_in;
      mu_ff    <= mu_in;
      d_ff     <= d_in;
      raddr_ff <= raddr_in;
      cnt_ff   <= cnt_in;
      last_ff  <= last_in;
      far_ff   <= far_in;
      ql_ff    <= ql_in;
      xa_ff    <= xa_in;
      k_ff     <= k_in;
      bi_ff    <= bi_in;
      ezero_ff <= ezero_in;
      p_ff     <= p_in;
      t_ff     <= t_in;
      acc_ff   <= acc_in;
      s_ff     <= s_in;
      sl_ff    <= sl_in;
      bpos_ff  <= bpos_in;
      bneg_ff  <= bneg_in;
      mh_ff    <= mh_in;
      mul_ff   <= op_a * op_b;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= q_cmd.data;
      end
      if (mem_re) begin
         w_ff <= mem[raddr_ff];
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

FILE: hdl/gaussian_rbf_activation_unit.sv
// Gaussian RBF activation unit, Q16.16. Weight items (func 0) store one weight
// per (channel, center); sample items (func 1) return phi = sum w*exp(-x) and its
// slope over centers mu_min + j*mu_step for j < K (see below), both saturated.
// Items enter a two-entry queue in front of the evaluation engine, so up to two
// items are taken while the engine is busy or a result waits on the output.
// At the engine a weight write or an out-of-range sample (returning zeros) is
// handled in ST_IDLE; a sample runs ST_D to ST_PL once per center for K centers
// (K = centers_used clamped to 2..NUM_CENTERS), then ST_M, ST_ML, ST_OUT. The
// steps follow the single shared 33x33 multiplier, which each center visits
// eight times, and the weight memory read. The weight memory has no reset; read only entries written since reset.
module gaussian_rbf_activation_unit import grbf_pkg::*; #(
   parameter int CHANNELS    = 64,
   parameter int NUM_CENTERS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  req_type               req_data,
   output logic                  req_full,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    q_full, q_empty, q_push, q_pop;
   cmd_type push_cmd, pop_cmd;

   // configuration registers; writes to unused indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MU_MIN:       cfg_in.mu_min       = csr_data;
            CSR_MU_STEP:      cfg_in.mu_step      = csr_data[30:0];
            CSR_GAUSS_COEFF:  cfg_in.gauss_coeff  = csr_data[30:0];
            CSR_DERIV_COEFF:  cfg_in.deriv_coeff  = csr_data[30:0];
            CSR_CENTERS_USED: cfg_in.centers_used = csr_data[5:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mu_min       <= '0;
         cfg_ff.mu_step      <= 31'd65536;
         cfg_ff.gauss_coeff  <= 31'd32768;
         cfg_ff.deriv_coeff  <= 31'd65536;
         cfg_ff.centers_used <= 6'd32;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify and filter incoming transfers
   grbf_front #(
      .CHANNELS    (CHANNELS),
      .NUM_CENTERS (NUM_CENTERS)
   ) u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (push_cmd)
   );

   // decouple the front from the engine
   grbf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (pop_cmd)
   );

   // weight memory, center sequencer and shared multiplier
   grbf_back #(
      .CHANNELS    (CHANNELS),
      .NUM_CENTERS (NUM_CENTERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_cmd     (pop_cmd),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/grbf_checker.sv
module grbf_checker import grbf_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // nothing waits and the queue is open right after reset
   a_reset_clean: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queue not clear after reset");

   // a waiting result holds until its transfer
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed");

   // a clipped result shows a limit value
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.saturated) |->
         (rsp_data.phi_value == 32'sh7fffffff || rsp_data.phi_value == 32'sh80000000 ||
          rsp_data.slope_value == 32'sh7fffffff || rsp_data.slope_value == 32'sh80000000))
      else $error("saturated flag without limit value");

endmodule

bind gaussian_rbf_activation_unit grbf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
